### rtl/core/anip_pkg.sv
// ----------------------------------------------------------------------------
// anip_pkg: shared types and constants of the address number interpolator
// Field widths, step codes and the control/status bundle of the divider.
// ----------------------------------------------------------------------------
package anip_pkg;

  // Payload widths
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int NUM_W = 16;
  localparam int STEP_W = 2;

  // Run length limit default
  localparam int MAX_RUN_DEF = 64;

  // House number steps: all numbers, or even/odd keeping parity
  localparam logic [NUM_W:0] STEP_ALL = 17'd1;
  localparam logic [NUM_W:0] STEP_PARITY = 17'd2;
  localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 2'd1;

  // Divider geometry: quotient below |delta| < 2^32, divisor below 2^16
  localparam int DIV_Q_W = 32;
  localparam int DIV_R_W = NUM_W;
  localparam int DIVIDEND_W = DIV_Q_W + DIV_R_W;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  typedef struct packed {
    logic start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIV_R_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic [DIV_Q_W-1:0] quotient;
  } div_stat_t;

endpackage

### rtl/core/anip_ifs.sv
// ----------------------------------------------------------------------------
// anip_ifs: channel interfaces of the address number interpolator
// Point request channel, result request channel and step register write.
// ----------------------------------------------------------------------------
interface anip_point_if;
  logic valid;
  logic ready;
  logic signed [anip_pkg::LAT_W-1:0] latitude;
  logic signed [anip_pkg::LON_W-1:0] longitude;
  logic [anip_pkg::NUM_W-1:0] house_number;
  logic first_of_way;

  modport source (output valid, latitude, longitude, house_number, first_of_way,
                  input ready);
  modport sink (input valid, latitude, longitude, house_number, first_of_way,
                output ready);
endinterface

interface anip_result_if;
  logic valid;
  logic ready;
  logic [anip_pkg::NUM_W-1:0] number_out;
  logic signed [anip_pkg::LAT_W-1:0] latitude_out;
  logic signed [anip_pkg::LON_W-1:0] longitude_out;
  logic last_of_run;
  logic truncated;

  modport source (output valid, number_out, latitude_out, longitude_out,
                  last_of_run, truncated, input ready);
  modport sink (input valid, number_out, latitude_out, longitude_out,
                last_of_run, truncated, output ready);
endinterface

interface anip_cfg_if;
  logic valid;
  logic ready;
  logic [anip_pkg::STEP_W-1:0] step_size;

  modport source (output valid, step_size, input ready);
  modport sink (input valid, step_size, output ready);
endinterface

### rtl/core/address_number_interpolator_core.sv
// ----------------------------------------------------------------------------
// address_number_interpolator_core: house number interpolation between points
// Takes address points of a way in order and emits every house number that
// lies strictly between two neighboring points, stepping by 1 or by 2, each
// with latitude and longitude placed linearly by number in 1e-7 degree
// units: prev + ((cur - prev) * (n - l)) / (h - l), truncated toward zero.
// A point that starts a way, follows no stored point, repeats the stored
// number or has no number between it and the stored one is only stored
// and emits nothing. Otherwise, for each of the two coordinates, S_MUL
// starts a 32x16 magnitude product into the shared restoring divider,
// which retires one quotient bit per cycle, and S_DIV applies sign and
// base; S_WRITE then hands the result to the output register once free.
// The point channel is not ready while a run is computed; the run's last
// result may wait at the output while the next point request is already
// taken. A run stops after MAX_RUN results; last_of_run marks its final
// result, and truncated too if numbers remained. The step register may be
// written while the block is idle; codes 0 and 1 step by one, 2 and 3 by two.
// ----------------------------------------------------------------------------
module address_number_interpolator_core #(
  parameter int MAX_RUN = anip_pkg::MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  anip_cfg_if.sink             cfg,
  anip_point_if.sink           points,
  anip_result_if.source        results
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int LAT_W = anip_pkg::LAT_W;
  localparam int LON_W = anip_pkg::LON_W;
  localparam int NUM_W = anip_pkg::NUM_W;
  localparam int Q_W = anip_pkg::DIV_Q_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_DIV   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state;

  // Step register, always writable
  logic [anip_pkg::STEP_W-1:0] step_size;

  // Stored point of the way
  logic signed [LAT_W-1:0] prev_lat;
  logic signed [LON_W-1:0] prev_lon;
  logic [NUM_W-1:0] prev_num;
  logic have_prev;

  // Run context: base point, deltas as sign and magnitude, progress
  logic signed [LAT_W-1:0] base_lat;
  logic signed [LON_W-1:0] base_lon;
  logic [NUM_W-1:0] base_num;
  logic up;
  logic [NUM_W-1:0] den;
  logic [Q_W-1:0] dmag_lat;
  logic [Q_W-1:0] dmag_lon;
  logic dneg_lat;
  logic dneg_lon;
  logic [NUM_W:0] num;
  logic [NUM_W:0] step;
  logic [CNT_W-1:0] count;
  logic sel_lon;
  logic signed [LAT_W-1:0] res_lat;
  logic signed [LON_W-1:0] res_lon;

  // Output register
  logic out_valid;
  logic [NUM_W-1:0] out_num;
  logic signed [LAT_W-1:0] out_lat;
  logic signed [LON_W-1:0] out_lon;
  logic out_last;
  logic out_trunc;

  anip_pkg::div_ctrl_t div_ctrl;
  anip_pkg::div_stat_t div_stat;

  // Accept-cycle comparisons against the stored point
  logic [LAT_W+1:0] d_lat;
  logic [LON_W:0] d_lon;
  logic [LAT_W+1:0] d_lat_abs;
  logic [LON_W:0] d_lon_abs;
  logic h_up;
  logic [NUM_W-1:0] h_den;
  logic [NUM_W:0] step_sel;
  logic emit;
  logic point_acc;

  // Result path
  logic [Q_W-1:0] dmag_sel;
  logic [LON_W:0] q_signed;
  logic [LON_W:0] coord_sum;
  logic [NUM_W:0] num_next;
  logic [CNT_W-1:0] count_next;
  logic run_full;
  logic run_done;
  logic out_free;

  anip_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  assign cfg.ready = 1'b1;
  assign points.ready = (state == S_IDLE);
  assign point_acc = points.valid && points.ready;

  assign d_lat = {{2{points.latitude[LAT_W-1]}}, points.latitude}
               - {{2{prev_lat[LAT_W-1]}}, prev_lat};
  assign d_lon = {points.longitude[LON_W-1], points.longitude}
               - {prev_lon[LON_W-1], prev_lon};
  assign d_lat_abs = d_lat[LAT_W+1] ? -d_lat : d_lat;
  assign d_lon_abs = d_lon[LON_W] ? -d_lon : d_lon;
  assign h_up = points.house_number > prev_num;
  assign h_den = h_up ? points.house_number - prev_num : prev_num - points.house_number;
  assign step_sel = step_size[1] ? anip_pkg::STEP_PARITY : anip_pkg::STEP_ALL;
  assign emit = have_prev && !points.first_of_way && (step_sel < {1'b0, h_den});

  // Multiply the selected delta magnitude by the number offset into the divider
  assign dmag_sel = sel_lon ? dmag_lon : dmag_lat;
  assign div_ctrl.start = (state == S_MUL);
  assign div_ctrl.dividend = anip_pkg::DIVIDEND_W'(dmag_sel)
                           * anip_pkg::DIVIDEND_W'(num[NUM_W-1:0]);
  assign div_ctrl.divisor = den;

  // Apply the delta sign and add the base coordinate
  always_comb begin
    if (sel_lon ? dneg_lon : dneg_lat) begin
      q_signed = -{1'b0, div_stat.quotient};
    end else begin
      q_signed = {1'b0, div_stat.quotient};
    end
    if (sel_lon) begin
      coord_sum = {base_lon[LON_W-1], base_lon} + q_signed;
    end else begin
      coord_sum = {{2{base_lat[LAT_W-1]}}, base_lat} + q_signed;
    end
  end

  assign num_next = num + step;
  assign count_next = count + 1'b1;
  assign run_full = (count_next == CNT_W'(MAX_RUN));
  assign run_done = (num_next >= {1'b0, den}) || run_full;
  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= anip_pkg::STEP_SIZE_RESET;
    end else if (cfg.valid) begin
      step_size <= cfg.step_size;
    end
  end

  // Sequencer: idle, start product and divide, wait, hand result out
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      have_prev <= 1'b0;
      prev_lat <= '0;
      prev_lon <= '0;
      prev_num <= '0;
      count <= '0;
      sel_lon <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (point_acc) begin
            // store the point now; the run keeps its own copy of the base
            prev_lat <= points.latitude;
            prev_lon <= points.longitude;
            prev_num <= points.house_number;
            have_prev <= 1'b1;
            count <= '0;
            sel_lon <= 1'b0;
            if (emit) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_stat.busy) begin
            if (sel_lon) begin
              state <= S_WRITE;
            end else begin
              sel_lon <= 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            count <= count_next;
            sel_lon <= 1'b0;
            state <= run_done ? S_IDLE : S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Run context and coordinate holding registers
  always_ff @(posedge clk) begin
    if (point_acc) begin
      base_lat <= prev_lat;
      base_lon <= prev_lon;
      base_num <= prev_num;
      up <= h_up;
      den <= h_den;
      dmag_lat <= d_lat_abs[Q_W-1:0];
      dneg_lat <= d_lat[LAT_W+1];
      dmag_lon <= d_lon_abs[Q_W-1:0];
      dneg_lon <= d_lon[LON_W];
      step <= step_sel;
      num <= step_sel;
    end else if (state == S_WRITE && out_free) begin
      num <= num_next;
    end
    if (state == S_DIV && !div_stat.busy && !sel_lon) begin
      res_lat <= coord_sum[LAT_W-1:0];
    end
    // hold the longitude here until the output register is free
    if (state == S_DIV && !div_stat.busy && sel_lon) begin
      res_lon <= coord_sum[LON_W-1:0];
    end
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE && out_free) begin
      out_num <= up ? base_num + num[NUM_W-1:0] : base_num - num[NUM_W-1:0];
      out_lat <= res_lat;
      out_lon <= res_lon;
      out_last <= run_done;
      out_trunc <= run_full && (num_next < {1'b0, den});
    end
  end

  assign results.valid = out_valid;
  assign results.number_out = out_num;
  assign results.latitude_out = out_lat;
  assign results.longitude_out = out_lon;
  assign results.last_of_run = out_last;
  assign results.truncated = out_trunc;

`ifndef SYNTHESIS
  // A new point request is never taken while the divider is still working
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    points.ready |-> !div_stat.busy)
    else $error("point request taken while divider busy");

  // The run counter never passes its limit
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RUN))
    else $error("run counter beyond limit");

  // A cut run always ends on the flagged result
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.truncated) |-> results.last_of_run)
    else $error("truncated result not last of run");
`endif

endmodule

### rtl/core/anip_divider.sv
// ----------------------------------------------------------------------------
// anip_divider: restoring divider, one quotient bit per cycle
// Divides a 48-bit magnitude by a 16-bit magnitude whose quotient is known
// to fit 32 bits; the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module anip_divider (
  input  logic                clk,
  input  logic                rst,
  input  anip_pkg::div_ctrl_t ctrl,
  output anip_pkg::div_stat_t stat
);

  logic [anip_pkg::DIV_R_W-1:0] rem;
  logic [anip_pkg::DIV_Q_W-1:0] quo;
  logic [anip_pkg::DIV_R_W-1:0] divisor;
  logic [anip_pkg::DIV_CNT_W-1:0] cnt;
  logic busy;

  logic [anip_pkg::DIV_R_W:0] shifted;
  logic [anip_pkg::DIV_R_W:0] trial;
  logic take;

  // trial subtract of the shifted remainder
  assign shifted = {rem, quo[anip_pkg::DIV_Q_W-1]};
  assign trial = shifted - {1'b0, divisor};
  assign take = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      cnt <= anip_pkg::DIV_CNT_W'(anip_pkg::DIV_Q_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      busy <= (cnt != anip_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= ctrl.dividend[anip_pkg::DIVIDEND_W-1:anip_pkg::DIV_Q_W];
      quo <= ctrl.dividend[anip_pkg::DIV_Q_W-1:0];
      divisor <= ctrl.divisor;
    end else if (busy) begin
      rem <= take ? trial[anip_pkg::DIV_R_W-1:0] : shifted[anip_pkg::DIV_R_W-1:0];
      quo <= {quo[anip_pkg::DIV_Q_W-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.quotient = quo;

endmodule

### verif/address_number_interpolator_checker.sv
// ----------------------------------------------------------------------------
// address_number_interpolator_checker: result predictor and comparator
// Watches the step register, point and result channels, works out the house
// numbers and coordinates that each accepted point request should produce
// and compares every accepted result against the oldest one still awaited.
// ----------------------------------------------------------------------------
module address_number_interpolator_checker #(
  parameter int MAX_RUN = anip_pkg::MAX_RUN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  anip_cfg_if     cfg,
  anip_point_if   points,
  anip_result_if  results,
  output int      mismatches,
  output int      awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_W = anip_pkg::LAT_W;
  localparam int LON_W = anip_pkg::LON_W;
  localparam int NUM_W = anip_pkg::NUM_W;
  localparam int STEP_W = anip_pkg::STEP_W;

  typedef struct {
    logic [NUM_W-1:0]        number;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic                    last_of_run;
    logic                    truncated;
  } address_t;

  address_t          awaited_addresses[$];
  logic [STEP_W-1:0] step_code;
  longint            base_lat;
  longint            base_lon;
  int                base_num;
  bit                have_base;

  initial mismatches = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Linear placement by number, division truncating toward zero.
  function automatic longint place_coord(longint from, longint to, int offset, int span);
    return from + ((to - from) * longint'(offset)) / longint'(span);
  endfunction

  function automatic bit past_end(int n, int stride, int num);
    return (stride > 0) ? (n >= num) : (n <= num);
  endfunction

  task automatic interpolate_point(longint lat, longint lon, int num, logic first);
    int       stride;
    int       n;
    int       produced;
    address_t a;
    if (have_base && !first && num != base_num) begin
      stride = (step_code >= anip_pkg::STEP_PARITY) ? int'(anip_pkg::STEP_PARITY)
                                                    : int'(anip_pkg::STEP_ALL);
      if (num < base_num)
        stride = -stride;
      produced = 0;
      n = base_num + stride;
      while (!past_end(n, stride, num) && produced < MAX_RUN) begin
        a.number = NUM_W'(n);
        a.latitude = LAT_W'(place_coord(base_lat, lat, n - base_num, num - base_num));
        a.longitude = LON_W'(place_coord(base_lon, lon, n - base_num, num - base_num));
        a.last_of_run = past_end(n + stride, stride, num) || produced == MAX_RUN - 1;
        a.truncated = !past_end(n + stride, stride, num) && produced == MAX_RUN - 1;
        awaited_addresses.push_back(a);
        produced++;
        n += stride;
      end
    end
    base_lat = lat;
    base_lon = lon;
    base_num = num;
    have_base = 1'b1;
  endtask

  task automatic check_result();
    address_t a;
    if (awaited_addresses.size() == 0) begin
      report_mismatch("result with nothing awaited, number_out",
                      longint'(results.number_out), longint'(-1));
    end else begin
      a = awaited_addresses.pop_front();
      if (results.number_out !== a.number)
        report_mismatch("number_out", longint'(results.number_out), longint'(a.number));
      if (results.latitude_out !== a.latitude)
        report_mismatch("latitude_out", longint'(results.latitude_out),
                        longint'(a.latitude));
      if (results.longitude_out !== a.longitude)
        report_mismatch("longitude_out", longint'(results.longitude_out),
                        longint'(a.longitude));
      if (results.last_of_run !== a.last_of_run)
        report_mismatch("last_of_run", longint'(results.last_of_run),
                        longint'(a.last_of_run));
      if (results.truncated !== a.truncated)
        report_mismatch("truncated", longint'(results.truncated), longint'(a.truncated));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      step_code = anip_pkg::STEP_SIZE_RESET;
      base_lat = '0;
      base_lon = '0;
      base_num = 0;
      have_base = 1'b0;
      awaited_addresses.delete();
    end else begin
      if (cfg.valid && cfg.ready)
        step_code = cfg.step_size;
      if (results.valid && results.ready)
        check_result();
      if (points.valid && points.ready)
        interpolate_point(longint'(points.latitude), longint'(points.longitude),
                          int'(points.house_number), points.first_of_way);
    end
    awaited <= awaited_addresses.size();
  end

endmodule

### verif/address_number_interpolator_core_test.sv
// ----------------------------------------------------------------------------
// address_number_interpolator_core_test: testbench of the interpolator core
// Drives directed and random point requests through several step settings,
// with random idling on both channels, a long result stall and a full drain
// pause; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module address_number_interpolator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_W = anip_pkg::LAT_W;
  localparam int LON_W = anip_pkg::LON_W;
  localparam int NUM_W = anip_pkg::NUM_W;
  localparam int STEP_W = anip_pkg::STEP_W;

  // Step register codes: 0 and 1 step by one, 2 and 3 by two.
  localparam logic [STEP_W-1:0] STEP_CODE_ZERO  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CODE_ONE   = STEP_W'(anip_pkg::STEP_ALL);
  localparam logic [STEP_W-1:0] STEP_CODE_TWO   = STEP_W'(anip_pkg::STEP_PARITY);
  localparam logic [STEP_W-1:0] STEP_CODE_THREE = 2'd3;

  // Extremes of the coordinate fields, full width and nominal range.
  localparam logic signed [LAT_W-1:0] LAT_TOP    = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic signed [LAT_W-1:0] LAT_BOTTOM = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic signed [LON_W-1:0] LON_TOP    = {1'b0, {(LON_W-1){1'b1}}};
  localparam logic signed [LON_W-1:0] LON_BOTTOM = {1'b1, {(LON_W-1){1'b0}}};
  localparam int LAT_SPAN = 900000000;
  localparam int LON_SPAN = 1800000000;

  localparam int NUM_TOP = (1 << NUM_W) - 1;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_CYCLES = 900;

  logic clk = 1'b0;
  logic rst = 1'b1;

  anip_cfg_if    cfg();
  anip_point_if  points();
  anip_result_if results();

  int mismatches;
  int awaited;

  // Idle chances in percent per cycle, set per phase by the stimulus.
  int send_idle_pct = 7;
  int recv_idle_pct = 51;
  bit stall_armed = 1'b0;

  // Last point offered; random points are mostly steps away from it.
  int                      trail_num;
  logic signed [LAT_W-1:0] trail_lat;
  logic signed [LON_W-1:0] trail_lon;

  address_number_interpolator_core #(.MAX_RUN(anip_pkg::MAX_RUN_DEF)) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .points  (points),
    .results (results)
  );

  address_number_interpolator_checker #(.MAX_RUN(anip_pkg::MAX_RUN_DEF)) interp_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .points     (points),
    .results    (results),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard limit: several times a run where every point caused a full run of
  // results under the slowest idling, plus the long result stall.
  initial begin
    #40_000_000;
    $display("FAIL address_number_interpolator_core");
    $finish;
  end

  // Result side: take results at random, and once the stimulus arms it,
  // hold ready low for a long stretch so the core backs up into the point
  // channel while the sender keeps offering requests.
  initial begin
    int hold_left;
    bit stall_spent;
    hold_left = 0;
    stall_spent = 1'b0;
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_armed && !stall_spent) begin
        hold_left = STALL_CYCLES;
        stall_spent = 1'b1;
      end
      if (hold_left > 0) begin
        results.ready = 1'b0;
        hold_left--;
      end else begin
        results.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one point request; return at the falling edge after it is taken,
  // with valid still high so the next request can follow without a gap.
  task automatic offer_point(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                             int num, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      points.valid = 1'b0;
      @(negedge clk);
    end
    points.valid = 1'b1;
    points.latitude = lat;
    points.longitude = lon;
    points.house_number = NUM_W'(num);
    points.first_of_way = first;
    do @(posedge clk); while (!points.ready);
    @(negedge clk);
    trail_num = num;
    trail_lat = lat;
    trail_lon = lon;
  endtask

  // Drop valid, wait until every awaited result is in, then let the core
  // settle for the extra time asked; ends on a falling edge.
  task automatic drain_results(int extra);
    points.valid = 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] code);
    cfg.valid = 1'b1;
    cfg.step_size = code;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Mostly short, well-formed stretches of a way; now and then a new way,
  // an equal or adjacent number, a long run that may be cut, or a wild jump.
  task automatic offer_random_point();
    int                      pick;
    int                      delta;
    int                      num;
    int                      drift;
    logic                    first;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    pick = $urandom_range(99);
    first = 1'b0;
    if (pick < 6) begin
      first = 1'b1;
      num = $urandom_range(NUM_TOP);
    end else if (pick < 10) begin
      num = $urandom_range(NUM_TOP);
    end else begin
      if (pick < 16)
        delta = $urandom_range(60, 80);
      else if (pick < 24)
        delta = $urandom_range(0, 2);
      else
        delta = $urandom_range(3, 14);
      if ($urandom_range(1) == 0)
        delta = -delta;
      num = trail_num + delta;
      if (num < 0 || num > NUM_TOP)
        num = trail_num - delta;
    end
    if (first || $urandom_range(3) == 0) begin
      lat = LAT_W'($urandom());
      lon = LON_W'($urandom());
    end else begin
      drift = int'($urandom_range(0, 8388608)) - 4194304;
      lat = LAT_W'(trail_lat + drift);
      drift = int'($urandom_range(0, 8388608)) - 4194304;
      lon = LON_W'(trail_lon + drift);
    end
    offer_point(lat, lon, num, first);
  endtask

  initial begin
    // Park every input at a known value before reset.
    points.valid = 1'b0;
    points.latitude = '0;
    points.longitude = '0;
    points.house_number = '0;
    points.first_of_way = 1'b0;
    cfg.valid = 1'b0;
    cfg.step_size = anip_pkg::STEP_SIZE_RESET;
    trail_num = 0;
    trail_lat = '0;
    trail_lon = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, step left at its reset value of one.
    offer_point(LAT_TOP, LON_BOTTOM, 0, 1'b0);            // no stored point yet
    offer_point(LAT_BOTTOM, LON_TOP, 5, 1'b0);            // full-swing coordinates
    offer_point(LAT_W'(LAT_SPAN), -LON_SPAN, 5, 1'b0);    // equal numbers
    offer_point(LAT_W'(-LAT_SPAN), LON_SPAN, 6, 1'b0);    // adjacent numbers
    offer_point('0, '0, 1, 1'b0);                         // downward run
    offer_point(LAT_TOP, LON_TOP, NUM_TOP, 1'b1);         // new way
    offer_point(LAT_BOTTOM, LON_BOTTOM, NUM_TOP - 65, 1'b0); // exactly a full run
    offer_point(LAT_TOP, LON_TOP, NUM_TOP, 1'b0);         // full run upward
    offer_point(LAT_W'(123), -456, NUM_TOP - 135, 1'b0);  // cut run downward
    offer_point(LAT_W'(-7), 7, 0, 1'b0);                  // cut run downward
    offer_point(LAT_W'(-1), -1, NUM_TOP, 1'b0);           // widest number span, cut run upward
    offer_point('0, '0, NUM_TOP - 2, 1'b0);               // a single number between
    offer_point(LAT_W'(1), 1, 100, 1'b1);
    drain_results(SETTLE_CYCLES);

    // Directed, stepping by two and keeping the stored parity.
    write_step(STEP_CODE_TWO);
    offer_point(LAT_W'(1000), 2000, 111, 1'b0);
    offer_point(LAT_W'(-5000), 3000, 108, 1'b0);
    offer_point(LAT_W'(LAT_SPAN), LON_SPAN, 110, 1'b0);   // two apart, nothing between
    offer_point(LAT_W'(-LAT_SPAN), -LON_SPAN, 113, 1'b0);
    offer_point(LAT_W'(42), -42, 113, 1'b0);
    offer_point(LAT_W'(-42), 42, 114, 1'b0);
    offer_point(LAT_TOP, LON_BOTTOM, 0, 1'b0);
    offer_point(LAT_BOTTOM, LON_TOP, 200, 1'b0);          // cut run by two
    offer_point(LAT_W'(77), 88, NUM_TOP, 1'b1);
    offer_point(LAT_W'(-77), -88, NUM_TOP - 135, 1'b0);
    drain_results(SETTLE_CYCLES);

    // Random phase one: code zero steps by one; sender rarely idles, the
    // receiver idles half the time, and one long result stall backs up
    // the point channel.
    write_step(STEP_CODE_ZERO);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      offer_random_point();
      if (i == 30)
        stall_armed = 1'b1;
    end
    drain_results(SETTLE_CYCLES);

    // Random phase two: code three steps by two; swap the idling, and
    // hold the sender once until every result is in.
    write_step(STEP_CODE_THREE);
    send_idle_pct = 51;
    recv_idle_pct = 7;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      offer_random_point();
      if (i == 35)
        drain_results(0);
    end
    drain_results(SETTLE_CYCLES);

    // Random phase three: back to step one, no idling on either side.
    write_step(STEP_CODE_ONE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < ITEMS_PER_PHASE; i++)
      offer_random_point();
    drain_results(SETTLE_CYCLES);

    if (mismatches == 0 && awaited == 0)
      $display("PASS address_number_interpolator_core");
    else
      $display("FAIL address_number_interpolator_core");
    $finish;
  end

endmodule
